@@ rtl/illt_pkg.sv @@
// illt_pkg: shared types and codes for the indexed linked list table.
// No dependencies.
package illt_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT   = 3'd0,
    KIND_DEL_IDX  = 3'd1,
    KIND_DEL_KEY  = 3'd2,
    KIND_MOD_KEY  = 3'd3,
    KIND_READ     = 3'd4,
    KIND_WALK     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_NO_MATCH = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,        // issue read of current slot
    S_WAIT,      // read data becomes available
    S_EVAL,      // look at read data
    S_UNLINK,    // fix neighbor links
    S_OUT        // hold result word until taken
  } state_e;

  localparam int unsigned MAX_RES = 63;

endpackage

@@ rtl/illt_ram.sv @@
// illt_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module illt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/illt_core.sv @@
// illt_core: controller FSM (illt_ctrl) and slot-memory datapath (illt_dpath) of the list table.
// Depends on illt_pkg and illt_ram.
module illt_ctrl (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] kind_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  // status from datapath
  input  logic       req_fast_i,
  input  logic       hit_i,
  input  logic       at_end_i,
  input  logic       last_word_i,
  // commands to datapath
  output logic       cmd_load_o,
  output logic       cmd_latch_o,
  output logic       cmd_step_o,
  output logic       cmd_match_o,
  output logic       cmd_mod_o,
  output logic       cmd_unlink_o
);
  import illt_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] op_q, op_d;

  // state and current operation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= KIND_INSERT;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    in_stall_o   = (state_q != S_IDLE);
    out_valid_o  = (state_q == S_OUT);
    cmd_load_o   = 1'b0;
    cmd_latch_o  = 1'b0;
    cmd_step_o   = 1'b0;
    cmd_match_o  = 1'b0;
    cmd_mod_o    = 1'b0;
    cmd_unlink_o = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_load_o = 1'b1;
        op_d       = kind_i;
        case (kind_i)
          KIND_INSERT, KIND_DEL_IDX, KIND_DEL_KEY, KIND_MOD_KEY, KIND_READ, KIND_WALK:
            state_d = req_fast_i ? S_OUT : S_RD;
          default: state_d = S_IDLE;
        endcase
      end
      S_RD:     state_d = S_WAIT;
      S_WAIT:   state_d = S_EVAL;
      S_EVAL: begin
        case (op_q)
          KIND_DEL_IDX: begin
            cmd_latch_o = 1'b1;
            state_d     = S_UNLINK;
          end
          KIND_READ: begin
            cmd_latch_o = 1'b1;
            state_d     = S_OUT;
          end
          KIND_WALK: begin
            cmd_step_o = 1'b1;
            state_d    = S_OUT;
          end
          KIND_DEL_KEY: begin
            cmd_match_o = 1'b1;
            if (hit_i) state_d = S_UNLINK;
            else if (at_end_i) state_d = S_OUT;
            else state_d = S_RD;
          end
          KIND_MOD_KEY: begin
            cmd_match_o = 1'b1;
            cmd_mod_o   = hit_i;
            state_d     = (hit_i || at_end_i) ? S_OUT : S_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_UNLINK: begin
        cmd_unlink_o = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: if (!out_stall_i) begin
        state_d = (op_q == KIND_WALK && !last_word_i) ? S_RD : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

module illt_dpath #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         kind_i,
  input  logic [5:0]         slot_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] new_value_i,
  // commands from controller
  input  logic               cmd_load_i,
  input  logic               cmd_latch_i,
  input  logic               cmd_step_i,
  input  logic               cmd_match_i,
  input  logic               cmd_mod_i,
  input  logic               cmd_unlink_i,
  // status to controller
  output logic               req_fast_o,
  output logic               hit_o,
  output logic               at_end_o,
  output logic               last_word_o,
  // result word
  output logic [2:0]         status_o,
  output logic [5:0]         slot_out_o,
  output logic signed [31:0] value_out_o,
  output logic [5:0]         count_o,
  output logic               last_o
);
  import illt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // memory ports
  logic            v_we, n_we, p_we, f_we;
  logic [AW-1:0]   v_wa, n_wa, p_wa, f_wa, rd_a, f_ra;
  logic [DATA_WIDTH-1:0] v_wd, v_rd;
  logic [AW-1:0]   n_wd, p_wd, n_rd, p_rd, f_wd, f_rd;

  illt_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd), .raddr_i(rd_a), .rdata_o(v_rd));
  illt_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_nxt (
    .clk_i, .we_i(n_we), .waddr_i(n_wa), .wdata_i(n_wd), .raddr_i(rd_a), .rdata_o(n_rd));
  illt_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prv (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(rd_a), .rdata_o(p_rd));
  // free stack; entries below the low-water mark were never written, so for them
  // the slot is taken as DEPTH-1-index instead of the memory contents
  illt_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd));

  logic [DEPTH-1:0] valid_q;
  logic [AW-1:0]    head_q, cur_q, nx_q, pv_q;
  logic [CW-1:0]    cnt_q, top_q, wm_q;
  logic [DATA_WIDTH-1:0] key_q, nv_q;
  logic [5:0]       steps_q;
  status_e          st_q;
  logic [5:0]       so_q;
  logic [31:0]      vo_q;
  logic             last_q;

  logic [AW-1:0]    top_idx;
  logic [AW-1:0]    pop_slot;
  logic [DATA_WIDTH-1:0] key_in, nv_in;
  logic             slot_ok;

  assign top_idx  = AW'(top_q - CW'(1));
  assign f_ra     = top_idx;
  assign pop_slot = (CW'(top_idx) < wm_q) ? (AW'(DEPTH - 1) - top_idx) : f_rd;
  assign key_in   = DATA_WIDTH'($unsigned(value_i));
  assign nv_in    = DATA_WIDTH'($unsigned(new_value_i));
  assign slot_ok  = (32'(slot_i) < 32'(DEPTH)) && (slot_i != 6'd0) && valid_q[AW'(slot_i)];

  function automatic logic [31:0] to32(input logic [DATA_WIDTH-1:0] v);
    return 32'(v);
  endfunction

  assign status_o    = st_q;
  assign slot_out_o  = so_q;
  assign value_out_o = vo_q;
  assign count_o     = 6'(cnt_q);
  assign last_o      = last_q;

  assign hit_o       = (v_rd == key_q);
  assign at_end_o    = (n_rd == '0);
  assign last_word_o = last_q;

  // requests answered without a memory walk
  always_comb begin
    case (kind_i)
      KIND_INSERT:                       req_fast_o = 1'b1;
      KIND_DEL_IDX, KIND_READ:           req_fast_o = !slot_ok;
      KIND_DEL_KEY, KIND_MOD_KEY, KIND_WALK: req_fast_o = (head_q == '0);
      default:                           req_fast_o = 1'b0;
    endcase
  end

  // memory write and read controls
  always_comb begin
    v_we = 1'b0; n_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
    v_wa = '0; n_wa = '0; p_wa = '0; f_wa = AW'(top_q);
    v_wd = '0; n_wd = '0; p_wd = '0; f_wd = '0;
    rd_a = cur_q;
    if (cmd_load_i && kind_i == KIND_INSERT && top_q != '0) begin
      v_we = 1'b1; v_wa = pop_slot; v_wd = key_in;
      n_we = 1'b1; n_wa = pop_slot; n_wd = head_q;
      // old head (or sentinel) points back; only the head's own prev may be stale
      p_we = 1'b1; p_wa = head_q;   p_wd = pop_slot;
    end
    if (cmd_mod_i) begin
      v_we = 1'b1; v_wa = cur_q; v_wd = nv_q;
    end
    if (cmd_unlink_i) begin
      p_we = 1'b1; p_wa = nx_q; p_wd = pv_q;
      if (cur_q != head_q) begin
        n_we = 1'b1; n_wa = pv_q; n_wd = nx_q;
      end
      if (top_q < CW'(DEPTH - 1)) begin
        f_we = 1'b1; f_wd = cur_q;
      end
    end
  end

  // list registers and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q  <= '0;
      cur_q   <= '0;
      nx_q    <= '0;
      pv_q    <= '0;
      cnt_q   <= '0;
      top_q   <= CW'(DEPTH - 1);
      wm_q    <= CW'(DEPTH - 1);
      key_q   <= '0;
      nv_q    <= '0;
      steps_q <= '0;
      st_q    <= ST_OK;
      so_q    <= '0;
      vo_q    <= '0;
      last_q  <= 1'b1;
    end else begin
      if (cmd_load_i) begin
        key_q   <= key_in;
        nv_q    <= nv_in;
        steps_q <= '0;
        last_q  <= 1'b1;
        case (kind_i)
          KIND_INSERT: begin
            cur_q <= head_q;
            if (top_q == '0) begin
              st_q <= ST_FULL;
              so_q <= '0;
              vo_q <= '0;
            end else begin
              st_q              <= ST_OK;
              valid_q[pop_slot] <= 1'b1;
              head_q            <= pop_slot;
              cnt_q             <= cnt_q + CW'(1);
              top_q             <= top_q - CW'(1);
              so_q              <= 6'(pop_slot);
              vo_q              <= to32(key_in);
              if (CW'(top_idx) < wm_q) wm_q <= CW'(top_idx);
            end
          end
          KIND_DEL_IDX, KIND_READ: begin
            cur_q <= AW'(slot_i);
            so_q  <= slot_i;
            vo_q  <= '0;
            st_q  <= slot_ok ? ST_OK : ST_BAD_SLOT;
          end
          KIND_DEL_KEY, KIND_MOD_KEY: begin
            cur_q <= head_q;
            so_q  <= '0;
            vo_q  <= '0;
            st_q  <= (head_q == '0) ? ST_NO_MATCH : ST_OK;
          end
          KIND_WALK: begin
            cur_q <= head_q;
            so_q  <= '0;
            vo_q  <= '0;
            st_q  <= (head_q == '0) ? ST_EMPTY : ST_OK;
          end
          default: ;
        endcase
      end
      // read or delete by slot: capture entry and links
      if (cmd_latch_i) begin
        nx_q <= n_rd;
        pv_q <= p_rd;
        vo_q <= to32(v_rd);
      end
      // walk: emit current entry and advance
      if (cmd_step_i) begin
        so_q    <= 6'(cur_q);
        vo_q    <= to32(v_rd);
        last_q  <= (n_rd == '0) || (steps_q == 6'(MAX_RES - 1));
        cur_q   <= n_rd;
        steps_q <= steps_q + 6'd1;
      end
      // key search: stop on a hit, else follow next link
      if (cmd_match_i) begin
        nx_q <= n_rd;
        pv_q <= p_rd;
        if (v_rd == key_q) begin
          so_q <= 6'(cur_q);
          vo_q <= cmd_mod_i ? to32(nv_q) : to32(v_rd);
        end else begin
          cur_q <= n_rd;
          if (n_rd == '0) st_q <= ST_NO_MATCH;
        end
      end
      if (cmd_unlink_i) begin
        valid_q[cur_q] <= 1'b0;
        if (cur_q == head_q) head_q <= nx_q;
        if (cnt_q != '0) cnt_q <= cnt_q - CW'(1);
        if (top_q < CW'(DEPTH - 1)) top_q <= top_q + CW'(1);
      end
    end
  end

endmodule

@@ rtl/indexed_linked_list_table.sv @@
// indexed_linked_list_table: doubly linked list over a slot table with free stack; uses illt_core.
// Flow: insert and requests rejected up front go straight to the result; by-slot read, delete,
//   key ops and walk read, wait and evaluate per entry; both deletes then unlink their entry.
// Requests: one at a time; the next is taken in the cycle after the last word leaves.
// Reset: valid bits, head and count cleared, free stack full, all asynchronously.
module indexed_linked_list_table #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [5:0]         slot_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] new_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [5:0]         slot_out_o,
  output logic signed [31:0] value_out_o,
  output logic [5:0]         count_o,
  output logic               last_o
);

  logic req_fast, hit, at_end, last_word;
  logic cmd_load, cmd_latch, cmd_step, cmd_match, cmd_mod, cmd_unlink;

  illt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .out_valid_o, .out_stall_i,
    .req_fast_i(req_fast), .hit_i(hit), .at_end_i(at_end), .last_word_i(last_word),
    .cmd_load_o(cmd_load), .cmd_latch_o(cmd_latch), .cmd_step_o(cmd_step),
    .cmd_match_o(cmd_match), .cmd_mod_o(cmd_mod), .cmd_unlink_o(cmd_unlink));

  illt_dpath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dpath (
    .clk_i, .rst_ni, .kind_i, .slot_i, .value_i, .new_value_i,
    .cmd_load_i(cmd_load), .cmd_latch_i(cmd_latch), .cmd_step_i(cmd_step),
    .cmd_match_i(cmd_match), .cmd_mod_i(cmd_mod), .cmd_unlink_i(cmd_unlink),
    .req_fast_o(req_fast), .hit_o(hit), .at_end_o(at_end), .last_word_o(last_word),
    .status_o, .slot_out_o, .value_out_o, .count_o, .last_o);

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for indexed_linked_list_table.
// Drives list operations through a burst driver, predicts results with a local list model.
// Depends on illt_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb_top;
  import illt_pkg::*;

  localparam int unsigned NSLOT = 64;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  slot;
    logic [31:0] value;
    logic [31:0] new_value;
  } op_t;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic [31:0] value_out;
    logic [5:0]  count;
    logic        last;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] kind_i = '0;
  logic [5:0] slot_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] new_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [5:0] slot_out_o;
  logic signed [31:0] value_out_o;
  logic [5:0] count_o;
  logic last_o;

  indexed_linked_list_table i_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // list model state
  logic [31:0] tbl_val [NSLOT];
  logic [5:0]  tbl_nxt [NSLOT];
  logic [5:0]  tbl_prv [NSLOT];
  bit          tbl_used [NSLOT];
  logic [5:0]  head_ptr;
  logic [5:0]  live_cnt;
  logic [5:0]  free_slots [$];

  op_t  pending_ops [$];
  res_t expected_words [$];
  int   n_mismatch = 0;
  int   n_words = 0;
  int   n_walks = 0;
  bit   hold_long = 1'b0;

  function automatic res_t mk(logic [2:0] st, logic [5:0] sl, logic [31:0] v, bit lst);
    res_t r;
    r.status = st; r.slot_out = sl; r.value_out = v; r.count = live_cnt; r.last = lst;
    return r;
  endfunction

  function automatic logic [5:0] find_key(logic [31:0] key);
    logic [5:0] idx;
    idx = head_ptr;
    for (int i = 0; i < NSLOT && idx != 0; i++) begin
      if (tbl_used[idx] && tbl_val[idx] == key) return idx;
      idx = tbl_nxt[idx];
    end
    return 0;
  endfunction

  function automatic logic [31:0] unlink(logic [5:0] s);
    logic [5:0] nx, pv;
    nx = tbl_nxt[s];
    pv = tbl_prv[s];
    tbl_used[s] = 0;
    tbl_prv[nx] = pv;
    if (s == head_ptr) head_ptr = nx;
    else tbl_nxt[pv] = nx;
    if (live_cnt > 0) live_cnt--;
    free_slots.push_front(s);
    return tbl_val[s];
  endfunction

  // predict words caused by one accepted request
  task automatic predict_list_op(op_t op);
    logic [5:0] s, idx, nx;
    logic [31:0] v;
    int k;
    case (op.kind)
      KIND_INSERT: begin
        if (free_slots.size() == 0) expected_words.push_back(mk(ST_FULL, 0, 0, 1));
        else begin
          s = free_slots.pop_front();
          tbl_val[s] = op.value; tbl_used[s] = 1;
          tbl_prv[head_ptr] = s; tbl_prv[s] = 0; tbl_nxt[s] = head_ptr;
          head_ptr = s; live_cnt++;
          expected_words.push_back(mk(ST_OK, s, op.value, 1));
        end
      end
      KIND_DEL_IDX, KIND_READ: begin
        if (op.slot == 0 || !tbl_used[op.slot])
          expected_words.push_back(mk(ST_BAD_SLOT, op.slot, 0, 1));
        else if (op.kind == KIND_READ)
          expected_words.push_back(mk(ST_OK, op.slot, tbl_val[op.slot], 1));
        else begin
          v = unlink(op.slot);
          expected_words.push_back(mk(ST_OK, op.slot, v, 1));
        end
      end
      KIND_DEL_KEY, KIND_MOD_KEY: begin
        s = find_key(op.value);
        if (s == 0) expected_words.push_back(mk(ST_NO_MATCH, 0, 0, 1));
        else if (op.kind == KIND_DEL_KEY) begin
          v = unlink(s);
          expected_words.push_back(mk(ST_OK, s, v, 1));
        end else begin
          tbl_val[s] = op.new_value;
          expected_words.push_back(mk(ST_OK, s, op.new_value, 1));
        end
      end
      KIND_WALK: begin
        n_walks++;
        idx = head_ptr;
        if (idx == 0) expected_words.push_back(mk(ST_EMPTY, 0, 0, 1));
        k = 0;
        while (idx != 0 && k < MAX_RES) begin
          nx = tbl_nxt[idx];
          expected_words.push_back(mk(ST_OK, idx, tbl_val[idx], nx == 0 || k == MAX_RES - 1));
          k++;
          idx = nx;
        end
      end
      default: ;
    endcase
  endtask

  // driver: bursts and gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_list_op('{kind_i, slot_i, value_i, new_value_i});
        void'(pending_ops.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        // hold current word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          if ($urandom_range(0, 2) == 0) begin
            gap_left <= $urandom_range(1, 6);
            in_valid_i <= 1'b0;
          end else begin
            in_valid_i <= 1'b1;
            {kind_i, slot_i, value_i, new_value_i} <=
              {pending_ops[0].kind, pending_ops[0].slot, pending_ops[0].value,
               pending_ops[0].new_value};
          end
        end else begin
          burst_left <= burst_left - 1;
          in_valid_i <= 1'b1;
          {kind_i, slot_i, value_i, new_value_i} <=
            {pending_ops[0].kind, pending_ops[0].slot, pending_ops[0].value,
             pending_ops[0].new_value};
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus long hold-offs
  int stall_phase = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (hold_long && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else if (stall_phase % 97 < 30) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) == 0);
  end

  // monitor
  always @(posedge clk_i) begin
    res_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_words++;
      if (expected_words.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word: slot %0d value %h", slot_out_o,
                                       value_out_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (exp_w.status !== status_o || exp_w.slot_out !== slot_out_o ||
            exp_w.value_out !== value_out_o || exp_w.count !== count_o ||
            exp_w.last !== last_o) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp st %0d sl %0d v %h c %0d l %0d, got %0d %0d %h %0d %0d",
                     exp_w.status, exp_w.slot_out, exp_w.value_out, exp_w.count, exp_w.last,
                     status_o, slot_out_o, value_out_o, count_o, last_o);
        end
      end
    end
  end

  function automatic logic [31:0] rnd_val(logic [31:0] pool [$]);
    if (pool.size() > 0 && $urandom_range(0, 3) != 0) return pool[$urandom_range(0, pool.size()-1)];
    return $urandom();
  endfunction

  task automatic push(logic [2:0] k, logic [5:0] s, logic [31:0] v, logic [31:0] nv);
    op_t o;
    o.kind = k; o.slot = s; o.value = v; o.new_value = nv;
    pending_ops.push_back(o);
  endtask

  task automatic drain();
    while (pending_ops.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_words.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  logic [31:0] keys [$];

  initial begin
    logic [31:0] v;
    for (int i = 0; i < NSLOT; i++) tbl_used[i] = 0;
    head_ptr = 0;
    live_cnt = 0;
    for (int i = 1; i < NSLOT; i++) free_slots.push_back(6'(i));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty cases, extremes, every kind
    push(KIND_WALK, 0, 0, 0);
    push(KIND_READ, 0, 0, 0);
    push(KIND_DEL_IDX, 63, 0, 0);
    push(KIND_DEL_KEY, 0, 32'h8000_0000, 0);
    push(KIND_MOD_KEY, 0, 32'h7fff_ffff, 0);
    push(KIND_INSERT, 0, 32'h8000_0000, 0);
    push(KIND_INSERT, 0, 32'h7fff_ffff, 0);
    push(KIND_INSERT, 0, 32'hffff_ffff, 0);
    push(KIND_INSERT, 0, 32'h0, 0);
    push(KIND_WALK, 0, 0, 0);
    push(KIND_READ, 2, 0, 0);
    push(KIND_MOD_KEY, 0, 32'hffff_ffff, 32'h5555_aaaa);
    push(3'd6, 6'h3f, 32'hffff_ffff, 32'hffff_ffff);
    push(3'd7, 0, 0, 0);
    push(KIND_DEL_IDX, 4, 0, 0);
    push(KIND_DEL_IDX, 2, 0, 0);
    push(KIND_DEL_KEY, 0, 32'h8000_0000, 0);
    push(KIND_READ, 0, 0, 0);
    push(KIND_WALK, 0, 0, 0);
    drain();

    // fill to full while receiver holds off, then long walks
    hold_long = 1'b1;
    for (int i = 0; i < 64; i++) push(KIND_INSERT, 0, $urandom(), 0);
    push(KIND_WALK, 0, 0, 0);
    push(KIND_WALK, 0, 0, 0);
    drain();
    hold_long = 1'b0;

    // random: mostly valid slots and existing keys
    for (int i = 0; i < 16; i++) begin
      v = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2: begin push(KIND_INSERT, 0, v, 0); keys.push_back(v); end
        3: push(KIND_DEL_IDX, 6'($urandom_range(0, 63)), 0, 0);
        4: push(KIND_DEL_KEY, 0, rnd_val(keys), 0);
        5: push(KIND_MOD_KEY, 0, rnd_val(keys), $urandom());
        6, 7: push(KIND_READ, 6'($urandom_range(0, 63)), 0, 0);
        8: push(KIND_WALK, 6'($urandom_range(0, 63)), v, $urandom());
        default: push(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), v, $urandom());
      endcase
      // sender idles until every outstanding word has arrived
      if (i == 8) drain();
    end
    drain();
    $display("covered %0d result words, %0d walks, full and empty table cases", n_words,
             n_walks);
    if (n_mismatch == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ indexed_linked_list_table.f @@
rtl/illt_pkg.sv
rtl/illt_ram.sv
rtl/illt_core.sv
rtl/indexed_linked_list_table.sv
bench/tb_top.sv
